[hw/rtl/ssd_pkg.sv]
// Shared types, command codes and segment constants for the seven-segment scan driver.
`timescale 1ns / 1ps

package ssd_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_NUMBER = 2'd1,
    CMD_MINUS  = 2'd2,
    CMD_CLEAR  = 2'd3
  } ssd_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_DONE
  } ssd_state_e;

  typedef struct packed {
    logic tick;
    logic minus;
    logic clear;
    logic conv_load;
    logic conv_step;
    logic find;
    logic load_out;
  } ssd_ctrl_t;

  typedef struct packed {
    logic conv_last;
  } ssd_stat_t;

  localparam int unsigned SegW = 7;
  localparam int unsigned EnW = 4;
  localparam int unsigned StoreDepth = 4;
  localparam int unsigned NumW = 14;

  localparam logic [NumW-1:0] MAX_NUMBER = 14'd9999;
  localparam logic [12:0] DIV10_MUL = 13'd6554;
  localparam int unsigned Div10Shift = 16;
  localparam logic [SegW-1:0] SEG_DASH = 7'h40;

  function automatic logic [SegW-1:0] digit_glyph(input logic [3:0] d);
    logic [SegW-1:0] g;
    case (d)
      4'd0: g = 7'h3F;
      4'd1: g = 7'h06;
      4'd2: g = 7'h5B;
      4'd3: g = 7'h4F;
      4'd4: g = 7'h66;
      4'd5: g = 7'h6D;
      4'd6: g = 7'h7D;
      4'd7: g = 7'h07;
      4'd8: g = 7'h7F;
      4'd9: g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

[hw/rtl/seven_segment_scan_driver.sv]
// Top level of the multiplexed seven-segment scan driver.
`timescale 1ns / 1ps

// Each request carries one command: a scan tick, a number to show, a minus
// sign or a clear. Every request returns exactly one response with the
// segment levels and digit enables (one-hot or all off) as they stand after
// the command. A tick, minus or clear request goes from idle to the done
// state; a number request is saturated at 9999 and converted one decimal
// digit per cycle through a single divide-by-ten unit, then passes the find
// state. In done, the response is loaded once the output register is free.
// A new request is accepted once the controller is back in idle, even while
// the previous response still waits in the output register.

module seven_segment_scan_driver import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      cmd_i,
  input  logic [15:0]     value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [SegW-1:0] segments_o,
  output logic [EnW-1:0]  digit_enable_o
);

  ssd_ctrl_t ctrl;
  ssd_stat_t stat;

  ssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ssd_datapath #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .value_i        (value_i),
    .stat_o         (stat),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o)
  );

endmodule

[hw/rtl/ssd_datapath.sv]
// Datapath: pattern store, decimal conversion, scan position and drive registers.
`timescale 1ns / 1ps

module ssd_datapath import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssd_ctrl_t             ctrl_i,
  input  logic [15:0]           value_i,
  output ssd_stat_t             stat_o,
  output logic [SegW-1:0]       segments_o,
  output logic [EnW-1:0]        digit_enable_o
);

  localparam int unsigned NDIG = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT);
  localparam logic [1:0] LastPos = 2'(NDIG - 1);

  logic [SegW-1:0] store_q [StoreDepth];
  logic [SegW-1:0] store_d [StoreDepth];
  logic [1:0]      first_q, first_d;
  logic [1:0]      scan_q, scan_d;
  logic            shown_q, shown_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic [EnW-1:0]  en_q, en_d;
  logic [NumW-1:0] work_q, work_d;
  logic [1:0]      idx_q, idx_d;
  logic [SegW-1:0] out_seg_q;
  logic [EnW-1:0]  out_en_q;

  logic [26:0]     prod;
  logic [NumW-1:0] quot;
  logic [NumW-1:0] rem;
  logic [NumW-1:0] sat_value;
  logic [1:0]      first_found;

  assign sat_value = (value_i > 16'(MAX_NUMBER)) ? MAX_NUMBER : value_i[NumW-1:0];
  assign prod = 27'(work_q) * 27'(DIV10_MUL);
  assign quot = 14'(prod[26:Div10Shift]);
  assign rem = work_q - ((quot << 3) + (quot << 1));

  always_comb begin
    first_found = LastPos;
    for (int i = int'(NDIG) - 2; i >= 0; i--) begin
      if (store_q[i] != digit_glyph(4'd0)) begin
        first_found = 2'(i);
      end
    end
  end

  always_comb begin
    store_d = store_q;
    first_d = first_q;
    scan_d  = scan_q;
    shown_d = shown_q;
    seg_d   = seg_q;
    en_d    = en_q;
    work_d  = work_q;
    idx_d   = idx_q;
    if (ctrl_i.tick) begin
      en_d = '0;
      if (shown_q) begin
        seg_d  = (scan_q < first_q) ? '0 : store_q[scan_q];
        en_d   = EnW'(1) << scan_q;
        scan_d = (scan_q == LastPos) ? 2'd0 : scan_q + 2'd1;
      end
    end
    if (ctrl_i.minus) begin
      for (int i = 0; i < int'(StoreDepth); i++) begin
        store_d[i] = '0;
      end
      store_d[0] = SEG_DASH;
      first_d    = 2'd0;
      shown_d    = 1'b1;
    end
    if (ctrl_i.clear) begin
      for (int i = 0; i < int'(StoreDepth); i++) begin
        store_d[i] = '0;
      end
      first_d = 2'd0;
      scan_d  = 2'd0;
      shown_d = 1'b0;
      seg_d   = '0;
      en_d    = '0;
    end
    if (ctrl_i.conv_load) begin
      work_d = sat_value;
      idx_d  = LastPos;
    end
    if (ctrl_i.conv_step) begin
      store_d[idx_q] = digit_glyph(rem[3:0]);
      work_d = quot;
      idx_d  = idx_q - 2'd1;
    end
    if (ctrl_i.find) begin
      first_d = first_found;
      shown_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(StoreDepth); i++) begin
        store_q[i] <= '0;
      end
      first_q <= '0;
      scan_q  <= '0;
      shown_q <= 1'b0;
      seg_q   <= '0;
      en_q    <= '0;
    end else begin
      store_q <= store_d;
      first_q <= first_d;
      scan_q  <= scan_d;
      shown_q <= shown_d;
      seg_q   <= seg_d;
      en_q    <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    idx_q  <= idx_d;
    if (ctrl_i.load_out) begin
      out_seg_q <= seg_q;
      out_en_q  <= en_q;
    end
  end

  assign stat_o.conv_last = (idx_q == 2'd0);
  assign segments_o = out_seg_q;
  assign digit_enable_o = out_en_q;

endmodule

[hw/rtl/ssd_ctrl.sv]
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps

module ssd_ctrl import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ssd_stat_t  stat_i,
  output ssd_ctrl_t  ctrl_o
);

  ssd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  ssd_cmd_e   cmd;
  logic       out_free;

  assign cmd = ssd_cmd_e'(cmd_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd == CMD_NUMBER) ? ST_CONV : ST_DONE;
        end
      end
      ST_CONV: begin
        if (stat_i.conv_last) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (cmd)
            CMD_TICK:   ctrl_o.tick      = 1'b1;
            CMD_NUMBER: ctrl_o.conv_load = 1'b1;
            CMD_MINUS:  ctrl_o.minus     = 1'b1;
            CMD_CLEAR:  ctrl_o.clear     = 1'b1;
            default:    ctrl_o           = '0;
          endcase
        end
      end
      ST_CONV: ctrl_o.conv_step = 1'b1;
      ST_FIND: ctrl_o.find = 1'b1;
      ST_DONE: ctrl_o.load_out = out_free;
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
